// ===== hdl/atcla_pkg.sv =====
// ----------------------------------------------------------------------------
// atcla_pkg
// Shared types, codes and character constants for the AT command line
// assembler.
// ----------------------------------------------------------------------------
`default_nettype none

package atcla_pkg;

  localparam int FifoDepthDef = 256;
  localparam int LineDepthDef = 128;

  localparam int MinCmdLen = 7;
  localparam int PrefixLen = 6;

  // depth of the request queue between front and back
  localparam int QDepth = 2;

  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;

  localparam logic [1:0] CmdRecv    = 2'd0;
  localparam logic [1:0] CmdRead    = 2'd1;
  localparam logic [1:0] CmdRelease = 2'd2;
  localparam logic [1:0] CmdFlush   = 2'd3;

  typedef enum logic [1:0] {
    OP_RECV,
    OP_READ,
    OP_RELEASE,
    OP_FLUSH
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_PARSE,
    ST_RESULT
  } state_e;

  typedef struct packed {
    op_e        op;
    logic       is_term;
    logic [7:0] byte_in;
    logic [6:0] read_index;
    logic [7:0] max_length;
  } item_t;

  function automatic logic is_term(input logic [7:0] c);
    return (c == ChCr) || (c == ChLf);
  endfunction

  // characters of "AT+DFU"
  function automatic logic [7:0] prefix_char(input logic [2:0] k);
    logic [7:0] c;
    case (k)
      3'd0:    c = 8'h41;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h2B;
      3'd3:    c = 8'h44;
      3'd4:    c = 8'h46;
      3'd5:    c = 8'h55;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/atcla_front.sv =====
// ----------------------------------------------------------------------------
// atcla_front
// Takes requests from the input channel, classifies them and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module atcla_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        cmd_i,
  input  wire logic [7:0]        byte_in_i,
  input  wire logic [6:0]        read_index_i,
  input  wire logic [7:0]        max_length_i,
  output logic                   q_valid_o,
  input  wire logic              q_ready_i,
  output atcla_pkg::item_t       q_item_o
);

  atcla_pkg::item_t ent_q [atcla_pkg::QDepth];
  atcla_pkg::item_t new_item;
  logic [1:0]       count_q, count_d;
  logic             wp_q, wp_d;
  logic             rp_q, rp_d;
  logic             push, pop;

  always_comb begin
    new_item.byte_in    = byte_in_i;
    new_item.read_index = read_index_i;
    new_item.max_length = max_length_i;
    new_item.is_term    = atcla_pkg::is_term(byte_in_i);
    unique case (cmd_i)
      atcla_pkg::CmdRecv:    new_item.op = atcla_pkg::OP_RECV;
      atcla_pkg::CmdRead:    new_item.op = atcla_pkg::OP_READ;
      atcla_pkg::CmdRelease: new_item.op = atcla_pkg::OP_RELEASE;
      atcla_pkg::CmdFlush:   new_item.op = atcla_pkg::OP_FLUSH;
    endcase
  end

  assign in_ready_o = (count_q != 2'(atcla_pkg::QDepth));
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = ent_q[rp_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_comb begin
    wp_d    = push ? ~wp_q : wp_q;
    rp_d    = pop ? ~rp_q : rp_q;
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wp_q    <= 1'b0;
      rp_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= new_item;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/atcla_back.sv =====
// ----------------------------------------------------------------------------
// atcla_back
// Carries out queued requests: line parser, receive FIFO, command store,
// release drain and the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module atcla_back #(
  parameter int FIFO_DEPTH = atcla_pkg::FifoDepthDef,
  parameter int LINE_DEPTH = atcla_pkg::LineDepthDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  output logic                   q_ready_o,
  input  wire atcla_pkg::item_t  q_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   ready_res_o,
  output logic [6:0]             command_length_o,
  output logic [7:0]             read_data_o,
  output logic [7:0]             queue_count_o,
  output logic                   overflow_o
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = PW + 1;
  localparam int LW = $clog2(LINE_DEPTH);
  localparam int RW = (LW > 8) ? LW : 8;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    return (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  atcla_pkg::state_e state_q, state_d;
  atcla_pkg::item_t  cur_q, cur_d;

  logic          held_q, held_d;
  logic [LW-1:0] len_q, len_d;
  logic          pfx_ok_q, pfx_ok_d;
  logic          dropped_q, dropped_d;
  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;

  logic [7:0] fifo_mem [FIFO_DEPTH];
  logic [7:0] fifo_rdata_q;
  logic [7:0] line_mem [LINE_DEPTH];
  logic [7:0] line_rdata_q;

  logic       fifo_we, fifo_re, line_we, line_re;
  logic       parse_en, parse_term, parse_match, parse_room, pfx_next;
  logic [7:0] parse_c;
  logic       drain_more, load_out;

  logic          out_valid_q, out_valid_d;
  logic          ready_res_q;
  logic [6:0]    cmd_len_q;
  logic [7:0]    read_data_q;
  logic [7:0]    queue_count_q;
  logic          overflow_q;

  logic [RW-1:0] len_w, ml_w, reported;
  logic [7:0]    data;
  logic [CW-1:0] count;

  // parser inputs
  always_comb begin
    if (state_q == atcla_pkg::ST_PARSE) begin
      parse_c    = fifo_rdata_q;
      parse_term = atcla_pkg::is_term(fifo_rdata_q);
    end else begin
      parse_c    = q_item_i.byte_in;
      parse_term = q_item_i.is_term;
    end
    parse_match = (len_q >= LW'(atcla_pkg::MinCmdLen)) && pfx_ok_q;
    parse_room  = (len_q < LW'(LINE_DEPTH - 1));
    pfx_next    = ((len_q == '0) || pfx_ok_q) &&
                  (parse_c == atcla_pkg::prefix_char(len_q[2:0]));
  end

  assign drain_more = !held_q && (rd_q != wr_q);
  assign load_out   = (state_q == atcla_pkg::ST_RESULT) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      atcla_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          state_d = (q_item_i.op == atcla_pkg::OP_RELEASE) ?
                    atcla_pkg::ST_DRAIN : atcla_pkg::ST_RESULT;
        end
      end
      atcla_pkg::ST_DRAIN: begin
        state_d = drain_more ? atcla_pkg::ST_PARSE : atcla_pkg::ST_RESULT;
      end
      atcla_pkg::ST_PARSE: begin
        state_d = atcla_pkg::ST_DRAIN;
      end
      atcla_pkg::ST_RESULT: begin
        if (load_out) begin
          state_d = atcla_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // actions
  always_comb begin
    q_ready_o = 1'b0;
    cur_d     = cur_q;
    held_d    = held_q;
    len_d     = len_q;
    pfx_ok_d  = pfx_ok_q;
    dropped_d = dropped_q;
    wr_d      = wr_q;
    rd_d      = rd_q;
    fifo_we   = 1'b0;
    fifo_re   = 1'b0;
    line_re   = 1'b0;
    line_we   = 1'b0;
    parse_en  = 1'b0;
    unique case (state_q)
      atcla_pkg::ST_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          cur_d = q_item_i;
          unique case (q_item_i.op)
            atcla_pkg::OP_RECV: begin
              if (held_q) begin
                if (ring_next(wr_q) != rd_q) begin
                  fifo_we = 1'b1;
                  wr_d    = ring_next(wr_q);
                end else begin
                  dropped_d = 1'b1;
                end
              end else begin
                parse_en = 1'b1;
              end
            end
            atcla_pkg::OP_READ: begin
              line_re = 1'b1;
            end
            atcla_pkg::OP_RELEASE: begin
              if (held_q || dropped_q) begin
                len_d = '0;
              end
              held_d    = 1'b0;
              dropped_d = 1'b0;
            end
            atcla_pkg::OP_FLUSH: begin
              wr_d      = '0;
              rd_d      = '0;
              dropped_d = 1'b0;
            end
          endcase
        end
      end
      atcla_pkg::ST_DRAIN: begin
        if (drain_more) begin
          fifo_re = 1'b1;
          rd_d    = ring_next(rd_q);
        end
      end
      atcla_pkg::ST_PARSE: begin
        parse_en = 1'b1;
      end
      atcla_pkg::ST_RESULT: begin
      end
    endcase

    if (parse_en) begin
      if (parse_term) begin
        if (parse_match) begin
          held_d = 1'b1;
        end else begin
          len_d = '0;
        end
      end else if (parse_room) begin
        line_we = 1'b1;
        len_d   = len_q + LW'(1);
        if (len_q < LW'(atcla_pkg::PrefixLen)) begin
          pfx_ok_d = pfx_next;
        end
      end
    end
  end

  // result values
  always_comb begin
    len_w = RW'(len_q);
    ml_w  = RW'(cur_q.max_length);
    if (!held_q || (ml_w == '0)) begin
      reported = '0;
    end else if (len_w >= ml_w) begin
      reported = ml_w - RW'(1);
    end else begin
      reported = len_w;
    end
    if ((cur_q.op == atcla_pkg::OP_READ) && held_q &&
        (RW'(cur_q.read_index) < reported)) begin
      data = line_rdata_q;
    end else begin
      data = 8'h00;
    end
    if (wr_q >= rd_q) begin
      count = CW'(wr_q) - CW'(rd_q);
    end else begin
      count = CW'(FIFO_DEPTH) - CW'(rd_q) + CW'(wr_q);
    end
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= atcla_pkg::ST_IDLE;
      held_q      <= 1'b0;
      len_q       <= '0;
      pfx_ok_q    <= 1'b0;
      dropped_q   <= 1'b0;
      wr_q        <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      len_q       <= len_d;
      pfx_ok_q    <= pfx_ok_d;
      dropped_q   <= dropped_d;
      wr_q        <= wr_d;
      rd_q        <= rd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (load_out) begin
      ready_res_q   <= held_q;
      cmd_len_q     <= 7'(reported);
      read_data_q   <= data;
      queue_count_q <= 8'(count);
      overflow_q    <= dropped_q;
    end
  end

  // receive fifo storage
  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_mem[wr_q] <= q_item_i.byte_in;
    end
    if (fifo_re) begin
      fifo_rdata_q <= fifo_mem[rd_q];
    end
  end

  // line storage
  always_ff @(posedge clk_i) begin
    if (line_we) begin
      line_mem[len_q] <= parse_c;
    end
    if (line_re) begin
      line_rdata_q <= line_mem[LW'(q_item_i.read_index)];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign ready_res_o      = ready_res_q;
  assign command_length_o = cmd_len_q;
  assign read_data_o      = read_data_q;
  assign queue_count_o    = queue_count_q;
  assign overflow_o       = overflow_q;

endmodule

`default_nettype wire

// ===== hdl/at_command_line_assembler.sv =====
// ----------------------------------------------------------------------------
// at_command_line_assembler
// Builds received characters into lines, keeps AT+DFU command lines and
// queues bytes in a receive FIFO while a command is held.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake                payload
//   in        input       in_valid_i / in_ready_o  cmd, byte_in, read_index, max_length
//   out       output      out_valid_o / out_ready_i ready_res, command_length,
//                                                  read_data, queue_count, overflow
//
//   receive, read and flush: queued, taken in ST_IDLE, result registered in ST_RESULT
//   release: each byte drained from the FIFO takes one FIFO read and one parser
//   step, up to FIFO_DEPTH-1 bytes
//   a two-entry request queue takes new requests while the back end works
//   reset clears control state only; no clearing pass, stores hold data
//   a result waiting on out_ready_i stalls the back end, not the queue
//
`default_nettype none

module at_command_line_assembler #(
  parameter int FIFO_DEPTH = atcla_pkg::FifoDepthDef,
  parameter int LINE_DEPTH = atcla_pkg::LineDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [7:0]  byte_in_i,
  input  wire logic [6:0]  read_index_i,
  input  wire logic [7:0]  max_length_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             ready_res_o,
  output logic [6:0]       command_length_o,
  output logic [7:0]       read_data_o,
  output logic [7:0]       queue_count_o,
  output logic             overflow_o
);

  logic             q_valid;
  logic             q_ready;
  atcla_pkg::item_t q_item;

  atcla_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .byte_in_i    (byte_in_i),
    .read_index_i (read_index_i),
    .max_length_i (max_length_i),
    .q_valid_o    (q_valid),
    .q_ready_i    (q_ready),
    .q_item_o     (q_item)
  );

  atcla_back #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_ready_o        (q_ready),
    .q_item_i         (q_item),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .ready_res_o      (ready_res_o),
    .command_length_o (command_length_o),
    .read_data_o      (read_data_o),
    .queue_count_o    (queue_count_o),
    .overflow_o       (overflow_o)
  );

  // back end takes one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && q_ready |=> !q_ready)
    else $error("back end took a request while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ready_res_o |-> command_length_o == 7'd0 && read_data_o == 8'd0)
    else $error("length or data reported with no command held");

  // with no command held every queued byte has gone through the parser
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ready_res_o |-> queue_count_o == 8'd0)
    else $error("bytes left queued with no command held");

endmodule

`default_nettype wire
